// ===== rtl/point_region_type_classifier_core_macros.svh =====
`ifndef POINT_REGION_TYPE_CLASSIFIER_CORE_MACROS_SVH
`define POINT_REGION_TYPE_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PRTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prtc_pkg.sv =====
package prtc_pkg;

    localparam int MAX_RULES   = 16;
    localparam int COORD_WIDTH = 32;
    localparam int SLAB_PAIRS  = 3;
    localparam int SLOT_W      = $clog2(MAX_RULES);
    localparam int PAIR_W      = $clog2(SLAB_PAIRS + 1);
    localparam int COUNT_W     = 5;
    localparam int TYPE_W      = 8;
    localparam int CODE_W      = 4;
    localparam int ORIENT_W    = 2;

    localparam logic [ORIENT_W-1:0] ORIENT_ZXY = 2'd1;
    localparam logic [ORIENT_W-1:0] ORIENT_YZX = 2'd2;
    localparam logic [ORIENT_W-1:0] ORIENT_XYZ = 2'd3;

    localparam logic CFG_ORIENTATION = 1'b0;
    localparam logic CFG_RULE_COUNT  = 1'b1;

    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    localparam logic [PAIR_W-1:0] PAIR_LIMIT = '0;

    typedef enum logic [CODE_W-1:0] {
        RC_NONE      = 4'd0,
        RC_FIRST_GT  = 4'd1,
        RC_FIRST_LT  = 4'd2,
        RC_SECOND_GT = 4'd3,
        RC_SECOND_LT = 4'd4,
        RC_THIRD_GT  = 4'd5,
        RC_THIRD_LT  = 4'd6,
        RC_FIRST_IN  = 4'd7,
        RC_SECOND_IN = 4'd8,
        RC_THIRD_IN  = 4'd9,
        RC_FS_IN     = 4'd10,
        RC_ST_IN     = 4'd11,
        RC_TF_IN     = 4'd12,
        RC_BOX       = 4'd13
    } code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_DONE
    } state_t;

    typedef struct packed {
        code_t                                 code;
        logic [TYPE_W-1:0]                     atype;
        logic signed [COORD_WIDTH-1:0]         limit;
        logic [SLAB_PAIRS-1:0][COORD_WIDTH-1:0] lows;
        logic [SLAB_PAIRS-1:0][COORD_WIDTH-1:0] highs;
    } rule_row_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first;
        logic signed [COORD_WIDTH-1:0] second;
        logic signed [COORD_WIDTH-1:0] third;
    } axes_t;

endpackage

// ===== rtl/prtc_match.sv =====
module prtc_match
    import prtc_pkg::*;
(
    input  rule_row_t row,
    input  axes_t     axes,
    output logic      hit
);

    logic [SLAB_PAIRS-1:0] in_first;
    logic [SLAB_PAIRS-1:0] in_second;
    logic [SLAB_PAIRS-1:0] in_third;

    // strict open slab per pair
    always_comb
    begin
        for (int k = 0; k < SLAB_PAIRS; k++)
        begin
            in_first[k]  = ($signed(row.lows[k]) < axes.first)
                           && (axes.first < $signed(row.highs[k]));
            in_second[k] = ($signed(row.lows[k]) < axes.second)
                           && (axes.second < $signed(row.highs[k]));
            in_third[k]  = ($signed(row.lows[k]) < axes.third)
                           && (axes.third < $signed(row.highs[k]));
        end
    end

    always_comb
    begin
        unique case (row.code)
            RC_FIRST_GT:  hit = axes.first > row.limit;
            RC_FIRST_LT:  hit = axes.first < row.limit;
            RC_SECOND_GT: hit = axes.second > row.limit;
            RC_SECOND_LT: hit = axes.second < row.limit;
            RC_THIRD_GT:  hit = axes.third > row.limit;
            RC_THIRD_LT:  hit = axes.third < row.limit;
            RC_FIRST_IN:  hit = in_first[0];
            RC_SECOND_IN: hit = in_second[0];
            RC_THIRD_IN:  hit = in_third[0];
            RC_FS_IN:     hit = in_first[0] && in_second[1];
            RC_ST_IN:     hit = in_second[0] && in_third[1];
            RC_TF_IN:     hit = in_third[0] && in_first[1];
            RC_BOX:       hit = in_first[0] && in_second[1] && in_third[2];
            default:      hit = 1'b0;
        endcase
    end

endmodule

// ===== rtl/point_region_type_classifier_core.sv =====
// Region rule table with point retagging. A load transfer writes one rule slot and
// gives no result. A classify transfer walks slots 0 .. rule_count-1 (saturated
// at 16) through the rule memory, one synchronous read per slot, before the result
// register is loaded; the scan is skipped when rule_count is zero or orientation is
// zero. Only one classify is in flight; a finished result waits in the output
// register while the next item is taken. Coordinates and bounds are signed Q16.16,
// compared exactly.
`include "point_region_type_classifier_core_macros.svh"

module point_region_type_classifier_core
    import prtc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [COUNT_W-1:0]            cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [SLOT_W-1:0]             rule_slot,
    input  logic [CODE_W-1:0]             rule_code,
    input  logic [TYPE_W-1:0]             assign_type,
    input  logic [PAIR_W-1:0]             pair_select,
    input  logic signed [COORD_WIDTH-1:0] bound_low,
    input  logic signed [COORD_WIDTH-1:0] bound_high,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    input  logic [TYPE_W-1:0]             current_type,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [TYPE_W-1:0]             node_type,
    output logic                          was_changed
);

    rule_row_t             rule_mem [MAX_RULES];
    rule_row_t             rd_row_reg;

    state_t                state_reg;
    state_t                state_next;
    logic [ORIENT_W-1:0]   orientation_reg;
    logic [COUNT_W-1:0]    rule_count_reg;
    logic [SLOT_W-1:0]     idx_reg;
    logic [SLOT_W-1:0]     last_idx_reg;
    axes_t                 axes_reg;
    axes_t                 axes_next;
    logic                  orient_ok;
    logic [TYPE_W-1:0]     type_reg;
    logic                  changed_reg;
    logic                  eval_pend_reg;
    logic                  eval_pend_next;
    logic                  out_valid_reg;
    logic [TYPE_W-1:0]     node_type_reg;
    logic                  was_changed_reg;

    logic                  in_xfer;
    logic                  load_xfer;
    logic                  class_xfer;
    logic                  rd_en;
    logic                  out_load;
    logic                  out_free;
    logic                  hit;
    logic [COUNT_W-1:0]    n_sat;
    logic                  skip_scan;

    assign in_xfer    = in_valid && !in_stall;
    assign load_xfer  = in_xfer && (func == FUNC_LOAD);
    assign class_xfer = in_xfer && (func == FUNC_CLASSIFY);
    assign out_free   = !out_valid_reg || !out_stall;

    assign n_sat = (rule_count_reg > COUNT_W'(MAX_RULES)) ? COUNT_W'(MAX_RULES)
                                                          : rule_count_reg;

    always_comb
    begin
        orient_ok = 1'b1;
        axes_next = '0;
        case (orientation_reg)
            ORIENT_ZXY: axes_next = '{first: coord_z, second: coord_x, third: coord_y};
            ORIENT_YZX: axes_next = '{first: coord_y, second: coord_z, third: coord_x};
            ORIENT_XYZ: axes_next = '{first: coord_x, second: coord_y, third: coord_z};
            default:    orient_ok = 1'b0;
        endcase
    end

    assign skip_scan = !orient_ok || (n_sat == '0);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orientation_reg <= ORIENT_ZXY;
            rule_count_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ORIENTATION: orientation_reg <= cfg_data[ORIENT_W-1:0];
                CFG_RULE_COUNT:  rule_count_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // rule memory: field-wise writes on load, one registered read per scan cycle
    always_ff @(posedge clk)
    begin
        if (load_xfer)
        begin
            rule_mem[rule_slot].code  <= code_t'(rule_code);
            rule_mem[rule_slot].atype <= assign_type;
            if (pair_select == PAIR_LIMIT)
            begin
                rule_mem[rule_slot].limit <= bound_low;
            end
            else
            begin
                rule_mem[rule_slot].lows[pair_select - PAIR_W'(1)]  <= bound_low;
                rule_mem[rule_slot].highs[pair_select - PAIR_W'(1)] <= bound_high;
            end
        end
        if (rd_en)
        begin
            rd_row_reg <= rule_mem[idx_reg];
        end
    end

    prtc_match u_match (
        .row  (rd_row_reg),
        .axes (axes_reg),
        .hit  (hit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (class_xfer)
                begin
                    state_next = skip_scan ? ST_DONE : ST_READ;
                end
            end
            ST_READ:
            begin
                if (idx_reg == last_idx_reg)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall       = 1'b1;
        rd_en          = 1'b0;
        eval_pend_next = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_READ:
            begin
                rd_en          = 1'b1;
                eval_pend_next = 1'b1;
            end
            ST_LAST:
            begin
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            eval_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            eval_pend_reg <= eval_pend_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan datapath
    always_ff @(posedge clk)
    begin
        if (class_xfer)
        begin
            axes_reg     <= axes_next;
            type_reg     <= current_type;
            changed_reg  <= 1'b0;
            idx_reg      <= '0;
            last_idx_reg <= SLOT_W'(n_sat - COUNT_W'(1));
        end
        else
        begin
            if (rd_en)
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
            if (eval_pend_reg && hit)
            begin
                type_reg    <= rd_row_reg.atype;
                changed_reg <= 1'b1;
            end
        end
        if (out_load)
        begin
            node_type_reg   <= type_reg;
            was_changed_reg <= changed_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign node_type   = node_type_reg;
    assign was_changed = was_changed_reg;

    `PRTC_ASSERT_NOW(a_eval_in_scan, eval_pend_reg,
        state_reg == ST_READ || state_reg == ST_LAST, "rule evaluated outside a scan")
    `PRTC_ASSERT_NOW(a_idx_bound, state_reg == ST_READ,
        idx_reg <= last_idx_reg, "scan index past last rule slot")
    `PRTC_ASSERT_NEXT(a_result_held, state_reg == ST_DONE && out_valid_reg && out_stall,
        state_reg == ST_DONE, "finished result dropped while output busy")

endmodule
